// ===== hw/rtl/lsbx_pkg.sv =====
// lsbx_pkg: shared types and constants for the lsb stego message extractor
// no dependencies; imported by the extractor and its checker

package lsbx_pkg;

    localparam int DELIM_BITS = 16;                      // window and compare width, 8..32
    localparam int FILL_W     = $clog2(DELIM_BITS + 1);  // window fill counter width
    localparam int CFG_W      = 16;                      // delimiter register width
    localparam logic [CFG_W-1:0] DELIM_RESET = 16'h2424;

    localparam int RQ_DEPTH = 4;                         // result queue entries
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_DONE = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] channel_value;
        logic       end_of_image;
    } pixel_t;

    typedef struct packed {
        logic [7:0] byte_value;
        status_t    status;
        logic       last;
    } result_t;

endpackage

// ===== hw/rtl/lsb_stego_message_extractor.sv =====
// lsb_stego_message_extractor: recovers a hidden message from channel lsbs
// depends on lsbx_pkg (types, widths, status codes)
//
//  channel   direction  payload    handshake
//  pixel     in         pixel_t    pixel_valid / pixel_ready
//  result    out        result_t   result_valid / result_ready
//  cfg       in         16 bits    cfg_wr_en (no wait, no read-back)
//
// one channel byte per cycle unless stalled: window shift, delimiter compare and byte packing
// are done in the accept cycle, results land in a 4-entry result queue
// a pixel is taken while the queue has room for two results, the most one pixel
// yields: a delimiter hit gives a final byte (if any bits are pending) plus done
// reset clears all image state and the queue, delimiter returns to 0x2424
// a stalled result output only backs up into pixel_ready once the queue holds more than two results

module lsb_stego_message_extractor
    import lsbx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    // configuration
    logic [CFG_W-1:0]      delim_reg;

    // image state
    logic [DELIM_BITS-1:0] win_reg,   win_next;
    logic [FILL_W-1:0]     fill_reg,  fill_next;
    logic [7:0]            acc_reg,   acc_next;
    logic [2:0]            bib_reg,   bib_next;
    logic                  found_reg, found_next;

    // result queue
    result_t               rq_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   cnt_reg,    cnt_next;

    logic                  take, pop;
    logic                  have_byte, have_status;
    logic [7:0]            byte_val;
    status_t               status_val;
    logic [1:0]            n_res;
    result_t               res0, res1;
    logic [31:0]           delim_ext;
    logic [DELIM_BITS-1:0] delim_cmp;
    logic                  full, match;
    logic [7:0]            acc_shift;
    logic [2:0]            bib_inc;

    // delimiter zero-extended or truncated to the window width
    assign delim_ext = {{(32-CFG_W){1'b0}}, delim_reg};
    assign delim_cmp = delim_ext[DELIM_BITS-1:0];

    assign take = pixel_valid && pixel_ready;
    assign pop  = result_valid && result_ready;

    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        acc_next    = acc_reg;
        bib_next    = bib_reg;
        found_next  = found_reg;
        have_byte   = 1'b0;
        have_status = 1'b0;
        byte_val    = acc_reg;
        status_val  = ST_BYTE;
        full        = (fill_reg == FILL_W'(DELIM_BITS));
        acc_shift   = {acc_reg[6:0], win_reg[DELIM_BITS-1]};
        bib_inc     = bib_reg + 3'd1;
        match       = 1'b0;

        if (found_reg)
        begin
            // message already out: only the end of image matters
            if (pixel.end_of_image)
            begin
                found_next = 1'b0;
                win_next   = '0;
                fill_next  = '0;
                acc_next   = '0;
                bib_next   = '0;
            end
        end
        else
        begin
            if (full)
            begin
                // bit leaving the window belongs to the message
                acc_next = acc_shift;
                bib_next = bib_inc;
                if (bib_reg == 3'd7)
                begin
                    have_byte = 1'b1;
                    byte_val  = acc_shift;
                    acc_next  = '0;
                    bib_next  = '0;
                end
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            win_next = {win_reg[DELIM_BITS-2:0], pixel.channel_value[0]};
            match    = (fill_next == FILL_W'(DELIM_BITS)) && (win_next == delim_cmp);

            if (match)
            begin
                // flush partial byte, zero padded at the bottom
                if (bib_next != 3'd0)
                begin
                    have_byte = 1'b1;
                    byte_val  = acc_next << (3'd0 - bib_next);
                end
                have_status = 1'b1;
                status_val  = ST_DONE;
                found_next  = 1'b1;
            end
            else if (pixel.end_of_image)
            begin
                have_status = 1'b1;
                status_val  = ST_NONE;
            end

            if (pixel.end_of_image)
            begin
                found_next = 1'b0;
                win_next   = '0;
                fill_next  = '0;
                acc_next   = '0;
                bib_next   = '0;
            end
        end
    end

    // pack up to two results, last marks the final one
    always_comb
    begin
        n_res           = {1'b0, have_byte} + {1'b0, have_status};
        res1.byte_value = '0;
        res1.status     = status_val;
        res1.last       = 1'b1;
        if (have_byte)
        begin
            res0.byte_value = byte_val;
            res0.status     = ST_BYTE;
            res0.last       = !have_status;
        end
        else
        begin
            res0 = res1;
        end
    end

    assign cnt_next = cnt_reg + (take ? RQ_CNT_W'(n_res) : RQ_CNT_W'(0))
                    - (pop ? RQ_CNT_W'(1) : RQ_CNT_W'(0));

    // room for the worst-case two results of one transfer
    assign pixel_ready  = (cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign result_valid = (cnt_reg != '0);
    assign result       = rq_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= DELIM_RESET;
            win_reg    <= '0;
            fill_reg   <= '0;
            acc_reg    <= '0;
            bib_reg    <= '0;
            found_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delim_reg <= cfg_wr_data;
            end
            if (take)
            begin
                win_reg    <= win_next;
                fill_reg   <= fill_next;
                acc_reg    <= acc_next;
                bib_reg    <= bib_next;
                found_reg  <= found_next;
                wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (take && (n_res != 2'd0))
        begin
            rq_reg[wr_ptr_reg] <= res0;
        end
        if (take && (n_res == 2'd2))
        begin
            rq_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= res1;
        end
    end

endmodule

// ===== hw/rtl/lsbx_checker.sv =====
// lsbx_port_checker: port-level assertions for the lsb stego message extractor
// depends on lsbx_pkg; bound to lsb_stego_message_extractor below

module lsbx_port_checker
    import lsbx_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input pixel_t           pixel,
    input logic             result_valid,
    input logic             result_ready,
    input result_t          result,
    input logic             cfg_wr_en,
    input logic [CFG_W-1:0] cfg_wr_data
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // status results carry a zero byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_BYTE) |-> (result.byte_value == 8'd0))
        else $error("status result with nonzero byte");

    // a status result always ends its transfer's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_BYTE) |-> result.last)
        else $error("status result not marked last");

    // input only backs up behind queued results
    a_ready_backup: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> result_valid)
        else $error("pixel stalled with empty result queue");

endmodule

bind lsb_stego_message_extractor lsbx_port_checker u_lsbx_checker (.*);
